// ===== rtl/s3w_pkg.sv =====
// shared types and constants of the weighted 3x3 smoothing unit
// no dependencies; used by smooth_3x3_weighted_unit and its testbench
package s3w_pkg;

    // configuration register widths and reset values
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_WIDTH_BITS-1:0]  RESET_IMAGE_WIDTH  = CFG_WIDTH_BITS'(640);
    localparam logic [CFG_HEIGHT_BITS-1:0] RESET_IMAGE_HEIGHT = CFG_HEIGHT_BITS'(480);

    // register word index, taken from paddr[2]
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    // defaults for the frame size limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W = 8;
    localparam int MIN_DIM = 3;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd             command;
        logic [PIX_W-1:0] pixel_value;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] smoothed_value;
        logic             frame_end;
    } t_out_beat;

endpackage

// ===== rtl/smooth_3x3_weighted_unit.sv =====
// weighted 3x3 smoothing filter over a raster pixel stream, two line buffers in block ram
// depends on s3w_pkg (beat types, register constants)
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (command, pixel_value)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (smoothed_value, frame_end)
//  cfg     | input     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// one beat per clock while in_stall is low; the line buffer read and the window update
// form a two-stage path whose second-stage registers feed a 4-entry output queue
// in_stall rises only when the output queue plus the result in flight would fill it
// reset is synchronous; the line buffers are not cleared and hold garbage until written
// a flush beat right after the last pixel of a frame forwards the older-row write in flight
module smooth_3x3_weighted_unit #(
    parameter int MAX_WIDTH  = s3w_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = s3w_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  s3w_pkg::t_in_beat                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output s3w_pkg::t_out_beat                o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [s3w_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [s3w_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [s3w_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int PEND_W  = $clog2(MAX_WIDTH + 2);
    localparam int PIX_W   = s3w_pkg::PIX_W;
    localparam int SUM_W   = PIX_W + 4;
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // configuration
    logic [s3w_pkg::CFG_WIDTH_BITS-1:0]  r_image_width;
    logic [s3w_pkg::CFG_HEIGHT_BITS-1:0] r_image_height;
    logic                                cfg_wr;
    logic [31:0]                         w32;
    logic [31:0]                         h32;

    // input-side control
    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [ROW_W-1:0]  r_in_row, n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [PEND_W-1:0] r_pending, n_pending;
    logic              in_acc;
    logic              is_flush;
    logic              flush_ok;
    logic              pix_emit;
    logic              a_emit;
    logic              out_last_row;
    logic              out_last_col;
    logic              out_border;
    logic [COL_W-1:0]  rd_addr;
    logic              fwd_hit;

    // line buffers
    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] older_q;
    logic [PIX_W-1:0] newer_q;

    // second stage
    logic             r_b_vld;
    logic             r_b_emit;
    logic             r_b_pix;
    logic             r_b_border;
    logic             r_b_fend;
    logic             r_b_sel_newer;
    logic             r_b_fwd;
    logic [COL_W-1:0] r_b_col;
    logic [PIX_W-1:0] r_b_pixel;
    logic [PIX_W-1:0] r_fwd_data;
    logic [PIX_W-1:0] r_win [9];
    logic [PIX_W-1:0] n_win [9];
    logic [SUM_W-1:0] win_sum;
    logic [PIX_W-1:0] flush_raw;
    s3w_pkg::t_out_beat b_result;

    // output queue
    s3w_pkg::t_out_beat r_q [Q_DEPTH];
    logic [QPTR_W-1:0]  r_q_wr, r_q_rd;
    logic [QCNT_W-1:0]  r_q_cnt, n_q_cnt;
    logic               q_push;
    logic               q_pop;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= s3w_pkg::RESET_IMAGE_WIDTH;
            r_image_height <= s3w_pkg::RESET_IMAGE_HEIGHT;
        end else if (cfg_wr) begin
            case (paddr[2])
                s3w_pkg::REG_IDX_WIDTH:  r_image_width  <= pwdata[s3w_pkg::CFG_WIDTH_BITS-1:0];
                s3w_pkg::REG_IDX_HEIGHT: r_image_height <= pwdata[s3w_pkg::CFG_HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            s3w_pkg::REG_IDX_WIDTH:  prdata = s3w_pkg::CFG_DATA_W'(r_image_width);
            s3w_pkg::REG_IDX_HEIGHT: prdata = s3w_pkg::CFG_DATA_W'(r_image_height);
            default:                 prdata = '0;
        endcase
    end

    // clamp the frame size into the supported range
    always_comb begin
        w32 = 32'(r_image_width);
        if (w32 < 32'(s3w_pkg::MIN_DIM)) w32 = 32'(s3w_pkg::MIN_DIM);
        if (w32 > 32'(MAX_WIDTH))        w32 = 32'(MAX_WIDTH);
        h32 = 32'(r_image_height);
        if (h32 < 32'(s3w_pkg::MIN_DIM)) h32 = 32'(s3w_pkg::MIN_DIM);
        if (h32 > 32'(MAX_HEIGHT))       h32 = 32'(MAX_HEIGHT);
    end

    // ---------------- first stage: position tracking and buffer reads ----------------
    assign o_in_stall = (r_q_cnt == QCNT_W'(Q_DEPTH)) ||
                        ((r_q_cnt == QCNT_W'(Q_DEPTH - 1)) && r_b_emit);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign is_flush   = (i_in_data.command == s3w_pkg::CMD_FLUSH);
    assign flush_ok   = (r_pending != '0) && (r_in_col == '0) && (r_in_row == '0);
    assign pix_emit   = (32'(r_pending) >= w32 + 32'd1);
    assign a_emit     = in_acc && (is_flush ? flush_ok : pix_emit);

    assign out_last_row = (32'(r_out_row) + 32'd1 >= h32);
    assign out_last_col = (32'(r_out_col) + 32'd1 >= w32);
    assign out_border   = (r_out_row == '0) || out_last_row || (r_out_col == '0) || out_last_col;

    assign rd_addr = is_flush ? r_out_col : r_in_col;
    // the older-row write of the previous pixel is still in flight in the second stage
    assign fwd_hit = r_b_vld && r_b_pix && (r_b_col == r_out_col);

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pending = r_pending;
        if (in_acc && !is_flush) begin
            if (32'(r_in_col) + 32'd1 >= w32) begin
                n_in_col = '0;
                n_in_row = (32'(r_in_row) + 32'd1 >= h32) ? '0 : ROW_W'(32'(r_in_row) + 32'd1);
            end else begin
                n_in_col = COL_W'(32'(r_in_col) + 32'd1);
            end
            if (!pix_emit) begin
                n_pending = r_pending + PEND_W'(1);
            end
        end
        if (in_acc && is_flush && flush_ok) begin
            n_pending = r_pending - PEND_W'(1);
        end
        if (a_emit) begin
            if (out_last_col) begin
                n_out_col = '0;
                n_out_row = out_last_row ? '0 : ROW_W'(32'(r_out_row) + 32'd1);
            end else begin
                n_out_col = COL_W'(32'(r_out_col) + 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pending <= '0;
            r_b_vld   <= 1'b0;
            r_b_emit  <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pending <= n_pending;
            r_b_vld   <= in_acc;
            r_b_emit  <= a_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_pix       <= !is_flush;
        r_b_border    <= out_border;
        r_b_fend      <= out_last_row && out_last_col;
        r_b_sel_newer <= out_last_row;
        r_b_fwd       <= fwd_hit;
        r_b_col       <= r_in_col;
        r_b_pixel     <= i_in_data.pixel_value;
        r_fwd_data    <= newer_q;
    end

    // newer row: read-first single port, raw pixel written on arrival
    always_ff @(posedge i_clk) begin
        if (in_acc && !is_flush) begin
            newer_mem[r_in_col] <= i_in_data.pixel_value;
        end
        if (in_acc) begin
            newer_q <= newer_mem[rd_addr];
        end
    end

    // older row: written in the second stage with the row read out of the newer buffer
    always_ff @(posedge i_clk) begin
        if (r_b_vld && r_b_pix) begin
            older_mem[r_b_col] <= newer_q;
        end
        if (in_acc) begin
            older_q <= older_mem[rd_addr];
        end
    end

    // ---------------- second stage: window shift and weighted sum ----------------
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_win[i] = r_win[i];
        end
        if (r_b_vld && r_b_pix) begin
            for (int r = 0; r < 3; r++) begin
                n_win[r*3]   = r_win[r*3+1];
                n_win[r*3+1] = r_win[r*3+2];
            end
            n_win[2] = older_q;
            n_win[5] = newer_q;
            n_win[8] = r_b_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= n_win[i];
            end
        end
    end

    // center weighs 8, each neighbor 1, then divide by 16
    always_comb begin
        win_sum = {1'b0, n_win[4], 3'b000};
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                win_sum = win_sum + SUM_W'(n_win[k]);
            end
        end
    end

    always_comb begin
        if (r_b_sel_newer) begin
            flush_raw = newer_q;
        end else if (r_b_fwd) begin
            flush_raw = r_fwd_data;
        end else begin
            flush_raw = older_q;
        end
        b_result.frame_end = r_b_fend;
        if (!r_b_pix) begin
            b_result.smoothed_value = flush_raw;
        end else if (r_b_border) begin
            b_result.smoothed_value = n_win[4];
        end else begin
            b_result.smoothed_value = win_sum[SUM_W-1:4];
        end
    end

    // ---------------- output queue ----------------
    assign q_push      = r_b_emit;
    assign o_out_valid = (r_q_cnt != '0);
    assign q_pop       = o_out_valid && !i_out_stall;
    assign o_out_data  = r_q[r_q_rd];

    always_comb begin
        n_q_cnt = r_q_cnt;
        if (q_push && !q_pop) begin
            n_q_cnt = r_q_cnt + QCNT_W'(1);
        end else if (!q_push && q_pop) begin
            n_q_cnt = r_q_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= '0;
            r_q_rd  <= '0;
            r_q_cnt <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
            if (q_push) begin
                r_q_wr <= r_q_wr + QPTR_W'(1);
            end
            if (q_pop) begin
                r_q_rd <= r_q_rd + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_q_wr] <= b_result;
        end
    end

    // ---------------- assertions ----------------
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_emit |-> (r_q_cnt != QCNT_W'(Q_DEPTH)))
        else $error("output queue pushed while full");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pending) <= 32'(MAX_WIDTH) + 32'd1)
        else $error("pending pixel count out of range");

    a_flush_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_flush && !flush_ok) |=> !r_b_emit && $stable(r_pending))
        else $error("ignored flush changed the pending count or produced a beat");

endmodule

// ===== tb/smooth_3x3_weighted_unit_tb.sv =====
// self-checking testbench for smooth_3x3_weighted_unit: raster frames in, smoothed frames out,
// each result checked against a local model of the line buffers and the 3x3 window
// depends on s3w_pkg and smooth_3x3_weighted_unit
module smooth_3x3_weighted_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import s3w_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 1200;

    localparam logic [CFG_ADDR_W-1:0] ADDR_IMAGE_WIDTH  = {REG_IDX_WIDTH, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_IMAGE_HEIGHT = {REG_IDX_HEIGHT, 2'b00};

    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_GRADIENT
    } t_fill;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_beat;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // local copy of the filter state
    logic [PIX_W-1:0]           older_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]           newer_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]           window [9];
    int unsigned                in_col  = 0;
    int unsigned                in_row  = 0;
    int unsigned                out_col = 0;
    int unsigned                out_row = 0;
    int unsigned                backlog = 0;
    logic [CFG_WIDTH_BITS-1:0]  cfg_width  = RESET_IMAGE_WIDTH;
    logic [CFG_HEIGHT_BITS-1:0] cfg_height = RESET_IMAGE_HEIGHT;
    t_out_beat                  expected_pixels [$];

    bit          src_idle_on       = 1'b1;
    bit          sink_idle_on      = 1'b1;
    int unsigned sink_wait         = 0;
    int unsigned hold_off_request  = 0;
    int unsigned quiet_cycles      = 0;
    int unsigned errors            = 0;
    int unsigned beats_sent        = 0;
    int unsigned effective_items   = 0;
    int unsigned results_checked   = 0;
    int unsigned frame_ends        = 0;
    int unsigned size_settings     = 0;

    smooth_3x3_weighted_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5ns clk = ~clk;

    function automatic int unsigned draw_wait(input bit enabled);
        if (!enabled || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic int unsigned frame_cols();
        if (cfg_width < MIN_DIM) return MIN_DIM;
        if (cfg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return cfg_width;
    endfunction

    function automatic int unsigned frame_rows();
        if (cfg_height < MIN_DIM) return MIN_DIM;
        if (cfg_height > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
        return cfg_height;
    endfunction

    function automatic void next_position(inout int unsigned col, inout int unsigned row,
                                          input int unsigned cols, input int unsigned rows);
        if (col + 1 >= cols) begin
            col = 0;
            row = (row + 1 >= rows) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    // value of the oldest buffered pixel; border pixels pass through raw
    function automatic t_out_beat smoothed_pixel(input logic [PIX_W-1:0] raw,
                                                 input int unsigned cols,
                                                 input int unsigned rows);
        t_out_beat   res;
        int unsigned acc;
        bit          on_border;
        on_border = (out_row == 0) || (out_row + 1 >= rows) ||
                    (out_col == 0) || (out_col + 1 >= cols);
        res.smoothed_value = raw;
        if (!on_border) begin
            acc = 8 * window[4];
            for (int k = 0; k < 9; k++) begin
                if (k != 4) acc += window[k];
            end
            res.smoothed_value = PIX_W'(acc / 16);
        end
        res.frame_end = (out_row + 1 >= rows) && (out_col + 1 >= cols);
        next_position(out_col, out_row, cols, rows);
        return res;
    endfunction

    function automatic void filter_step(input t_in_beat b);
        int unsigned      cols;
        int unsigned      rows;
        int unsigned      c;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] raw;
        t_out_beat        res;
        cols = frame_cols();
        rows = frame_rows();
        if (b.command == CMD_FLUSH) begin
            // only honored at a frame boundary with pixels still buffered
            if (backlog == 0 || in_col != 0 || in_row != 0) return;
            raw = (out_row + 1 >= rows) ? newer_line[out_col] : older_line[out_col];
            res = smoothed_pixel(raw, cols, rows);
            res.smoothed_value = raw;
            expected_pixels.push_back(res);
            backlog--;
            effective_items++;
            return;
        end
        c = in_col;
        top = older_line[c];
        mid = newer_line[c];
        older_line[c] = mid;
        newer_line[c] = b.pixel_value;
        for (int r = 0; r < 3; r++) begin
            window[r * 3]     = window[r * 3 + 1];
            window[r * 3 + 1] = window[r * 3 + 2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = b.pixel_value;
        next_position(in_col, in_row, cols, rows);
        effective_items++;
        if (backlog >= cols + 1) begin
            expected_pixels.push_back(smoothed_pixel(window[4], cols, rows));
        end else begin
            backlog++;
        end
    endfunction

    function automatic t_in_beat pixel_beat(input logic [PIX_W-1:0] value);
        t_in_beat b;
        b.command     = CMD_PIXEL;
        b.pixel_value = value;
        return b;
    endfunction

    function automatic t_in_beat flush_beat();
        t_in_beat b;
        b.command     = CMD_FLUSH;
        b.pixel_value = PIX_W'($urandom);
        return b;
    endfunction

    function automatic logic [PIX_W-1:0] fill_pixel(input t_fill fill);
        case (fill)
            FILL_EXTREME:  return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            FILL_GRADIENT: return PIX_W'(in_col * 9 + in_row * 5 + $urandom_range(0, 3));
            default:       return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_beat(input t_in_beat b);
        int unsigned gap;
        gap = draw_wait(src_idle_on);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        beats_sent++;
        filter_step(b);
    endtask

    // pixels up to the next frame boundary, with a stray flush now and then
    task automatic send_frame(input t_fill fill);
        do begin
            send_beat(pixel_beat(fill_pixel(fill)));
            if ($urandom_range(0, 24) == 0 && (in_col != 0 || in_row != 0)) begin
                send_beat(flush_beat());
            end
        end while (in_col != 0 || in_row != 0);
    endtask

    task automatic finish_frame();
        while (in_col != 0 || in_row != 0) send_beat(pixel_beat(PIX_W'($urandom)));
        while (backlog != 0) send_beat(flush_beat());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_size_regs();
        logic [CFG_DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_IMAGE_WIDTH, '0, rd);
        if (rd !== CFG_DATA_W'(cfg_width)) begin
            $error("image_width: expected %0d, got %0d", cfg_width, rd);
            errors++;
        end
        apb_access(1'b0, ADDR_IMAGE_HEIGHT, '0, rd);
        if (rd !== CFG_DATA_W'(cfg_height)) begin
            $error("image_height: expected %0d, got %0d", cfg_height, rd);
            errors++;
        end
    endtask

    task automatic set_frame_size(input int unsigned w_raw, input int unsigned h_raw);
        logic [CFG_DATA_W-1:0] ignored;
        apb_access(1'b1, ADDR_IMAGE_WIDTH, CFG_DATA_W'(w_raw), ignored);
        cfg_width = CFG_WIDTH_BITS'(w_raw);
        apb_access(1'b1, ADDR_IMAGE_HEIGHT, CFG_DATA_W'(h_raw), ignored);
        cfg_height = CFG_HEIGHT_BITS'(h_raw);
        size_settings++;
        check_size_regs();
    endtask

    // two back-to-back 3x3 frames: flat white, then a dark center in white
    task automatic test_directed_frames();
        check_size_regs();
        set_frame_size(3, 3);
        send_beat(flush_beat());
        for (int k = 0; k < 9; k++) begin
            send_beat(pixel_beat(8'hff));
            if (k == 3) send_beat(flush_beat());
        end
        for (int k = 0; k < 9; k++) send_beat(pixel_beat((k == 4) ? 8'h00 : 8'hff));
        repeat (4) send_beat(flush_beat());
        send_beat(flush_beat());
    endtask

    // out-of-range sizes clamp to the widest row, the tallest frame and the minimum
    task automatic test_size_extremes();
        drain();
        set_frame_size(2047, 0);
        send_frame(FILL_GRADIENT);
        finish_frame();
        drain();
        set_frame_size(0, 8191);
        send_frame(FILL_RANDOM);
        finish_frame();
        drain();
        set_frame_size(1, 2);
        send_frame(FILL_EXTREME);
        finish_frame();
    endtask

    // narrower and shorter, then taller, while a frame is half in
    task automatic test_mid_frame_resize();
        drain();
        set_frame_size(12, 6);
        send_frame(FILL_RANDOM);
        repeat (3 * 12 + 5) send_beat(pixel_beat(PIX_W'($urandom)));
        drain();
        set_frame_size(7, 4);
        finish_frame();
        send_frame(FILL_EXTREME);
        repeat (10) send_beat(pixel_beat(PIX_W'($urandom)));
        drain();
        set_frame_size(7, 9);
        finish_frame();
    endtask

    // output held off long enough that the unit fills and stalls its input
    task automatic test_output_hold();
        drain();
        set_frame_size(10, 8);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_off_request = LONG_HOLD;
        send_frame(FILL_RANDOM);
        send_frame(FILL_GRADIENT);
        finish_frame();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int unsigned start_items;
        int unsigned sel;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned frames;
        start_items = effective_items;
        while (effective_items - start_items < RANDOM_ITEMS) begin
            finish_frame();
            drain();
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                w_raw = $urandom_range(1025, 2047);
                h_raw = $urandom_range(0, 3);
            end else if (sel < 4) begin
                w_raw = $urandom_range(25, 64);
                h_raw = $urandom_range(3, 8);
            end else begin
                w_raw = $urandom_range(0, 24);
                h_raw = $urandom_range(0, 8);
            end
            set_frame_size(w_raw, h_raw);
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            frames = (sel == 0) ? 1 : $urandom_range(1, 3);
            repeat (frames) begin
                send_frame(t_fill'($urandom_range(0, 2)));
                // partial flush leaves the next frame offset against the buffered tail
                if (backlog > 1 && $urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, backlog - 1)) send_beat(flush_beat());
                end
                if ($urandom_range(0, 3) == 0) send_beat(flush_beat());
            end
        end
        finish_frame();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            results_checked++;
            if (out_beat.frame_end) frame_ends++;
            if (expected_pixels.size() == 0) begin
                $error("result %0h arrived with nothing expected", out_beat);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (out_beat.smoothed_value !== want.smoothed_value) begin
                    $error("smoothed_value: expected %0d, got %0d",
                           want.smoothed_value, out_beat.smoothed_value);
                    errors++;
                end
                if (out_beat.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0d, got %0d",
                           want.frame_end, out_beat.frame_end);
                    errors++;
                end
            end
            sink_wait = draw_wait(sink_idle_on);
        end
        if (hold_off_request != 0) begin
            sink_wait = hold_off_request;
            hold_off_request = 0;
        end
        if (sink_wait != 0) begin
            out_stall <= 1'b1;
            sink_wait--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) window[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_size_extremes();
        test_mid_frame_resize();
        test_output_hold();
        test_random_frames();
        drain();
        if (expected_pixels.size() != 0) begin
            $error("%0d expected results never arrived", expected_pixels.size());
            errors++;
        end
        $display("covered %0d input beats (%0d took effect), %0d results checked, %0d frame ends",
                 beats_sent, effective_items, results_checked, frame_ends);
        $display("frame size set %0d times, from 3x3 up to 1024 columns and 4096 rows",
                 size_settings);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
